[design/uads_pkg.sv]
// ----------------------------------------------------------------------------
// uads_pkg
// Shared types and constants for the USB audio descriptor scanner: descriptor
// codes, register indexes, configuration and result bundles.
// ----------------------------------------------------------------------------
package uads_pkg;

   // Descriptor type and field codes
   localparam logic [7:0] TYPE_INTERFACE    = 8'h04;
   localparam logic [7:0] TYPE_ENDPOINT     = 8'h05;
   localparam logic [1:0] ATTR_TYPE_MASK    = 2'h3;
   localparam int unsigned ADDR_DIR_IN_BIT  = 7;
   localparam logic [3:0] ADDR_NUM_MASK     = 4'hF;
   localparam logic [7:0] INTERFACE_MIN_LEN = 8'd9;
   localparam logic [7:0] MIN_DESC_LEN      = 8'd2;

   // Byte positions inside a descriptor
   localparam logic [7:0] POS_LENGTH   = 8'd0;
   localparam logic [7:0] POS_TYPE     = 8'd1;
   localparam logic [7:0] POS_IF_NUM   = 8'd2;
   localparam logic [7:0] POS_IF_CLASS = 8'd5;
   localparam logic [7:0] POS_IF_SUB   = 8'd6;
   localparam logic [7:0] POS_IF_PROTO = 8'd7;
   localparam logic [7:0] POS_EP_ADDR  = 8'd2;
   localparam logic [7:0] POS_EP_ATTR  = 8'd3;

   // Register file
   localparam int unsigned CSR_ADDR_W = 4;
   localparam int unsigned CSR_DATA_W = 32;

   typedef enum logic [1:0] {
      CSR_AUDIO_CLASS    = 2'd0,
      CSR_UAC2_PROTOCOL  = 2'd1,
      CSR_STREAM_SUBCLS  = 2'd2,
      CSR_ISOCH_TYPE     = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [7:0] audio_class;
      logic [7:0] uac2_protocol;
      logic [7:0] streaming_subclass;
      logic [1:0] isoch_type;
   } cfg_type;

   typedef struct packed {
      logic       audio_seen;
      logic [7:0] in_interface;
      logic [3:0] in_endpoint;
      logic [4:0] in_doorbell;
      logic [7:0] out_interface;
      logic [3:0] out_endpoint;
      logic [4:0] out_doorbell;
   } result_type;

endpackage

[design/uads_scan.sv]
// ----------------------------------------------------------------------------
// uads_scan
// Descriptor chain walker: holds the scan state, updates it for one byte per
// step and presents the summary that the step would give on a last byte.
// ----------------------------------------------------------------------------
module uads_scan (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step_en,
   input  logic [7:0]           step_byte,
   input  logic                 step_last,
   input  uads_pkg::cfg_type    cfg,
   output uads_pkg::result_type result
);
   import uads_pkg::*;

   logic [7:0] pos_ff,          pos_in;
   logic [7:0] length_ff,       length_in;
   logic [7:0] type_ff,         type_in;
   logic [7:0] intf_num_ff,     intf_num_in;
   logic [7:0] intf_sub_ff,     intf_sub_in;
   logic       class_match_ff,  class_match_in;
   logic       ep_pending_ff,   ep_pending_in;
   logic [7:0] pending_intf_ff, pending_intf_in;
   logic [7:0] ep_addr_ff,      ep_addr_in;
   logic       stopped_ff,      stopped_in;
   logic       found_ff,        found_in;
   logic [7:0] cap_intf_ff,     cap_intf_in;
   logic [3:0] cap_ep_ff,       cap_ep_in;
   logic       cap_valid_ff,    cap_valid_in;
   logic [7:0] play_intf_ff,    play_intf_in;
   logic [3:0] play_ep_ff,      play_ep_in;
   logic       play_valid_ff,   play_valid_in;

   logic       short_stop;
   logic [8:0] pos_next_wide;

   // Next scan state for the byte in hand
   always_comb begin
      pos_in          = pos_ff;
      length_in       = length_ff;
      type_in         = type_ff;
      intf_num_in     = intf_num_ff;
      intf_sub_in     = intf_sub_ff;
      class_match_in  = class_match_ff;
      ep_pending_in   = ep_pending_ff;
      pending_intf_in = pending_intf_ff;
      ep_addr_in      = ep_addr_ff;
      stopped_in      = stopped_ff;
      found_in        = found_ff;
      cap_intf_in     = cap_intf_ff;
      cap_ep_in       = cap_ep_ff;
      cap_valid_in    = cap_valid_ff;
      play_intf_in    = play_intf_ff;
      play_ep_in      = play_ep_ff;
      play_valid_in   = play_valid_ff;
      short_stop      = 1'b0;
      pos_next_wide   = {1'b0, pos_ff} + 9'd1;

      if (!stopped_ff) begin
         priority if (pos_ff == POS_LENGTH) begin
            length_in = step_byte;
            if (step_byte < MIN_DESC_LEN) begin
               stopped_in    = 1'b1;
               ep_pending_in = 1'b0;
               short_stop    = 1'b1;
            end
         end else if (pos_ff == POS_TYPE) begin
            type_in = step_byte;
            if (step_byte != TYPE_ENDPOINT) begin
               ep_pending_in = 1'b0;
            end
         end else if (type_ff == TYPE_INTERFACE) begin
            // Interface fields
            if (pos_ff == POS_IF_NUM) begin
               intf_num_in = step_byte;
            end
            if (pos_ff == POS_IF_CLASS) begin
               class_match_in = (step_byte == cfg.audio_class);
            end
            if (pos_ff == POS_IF_SUB) begin
               intf_sub_in = step_byte;
            end
            if (pos_ff == POS_IF_PROTO && length_ff >= INTERFACE_MIN_LEN &&
                class_match_ff && step_byte == cfg.uac2_protocol) begin
               found_in = 1'b1;
               if (intf_sub_ff == cfg.streaming_subclass) begin
                  ep_pending_in   = 1'b1;
                  pending_intf_in = intf_num_ff;
               end
            end
         end else if (type_ff == TYPE_ENDPOINT && ep_pending_ff) begin
            // Endpoint right after a streaming interface
            if (pos_ff == POS_EP_ADDR) begin
               ep_addr_in = step_byte;
            end
            if (pos_ff == POS_EP_ATTR) begin
               if ((step_byte[1:0] & ATTR_TYPE_MASK) == cfg.isoch_type) begin
                  if (ep_addr_ff[ADDR_DIR_IN_BIT]) begin
                     cap_intf_in  = pending_intf_ff;
                     cap_ep_in    = ep_addr_ff[3:0] & ADDR_NUM_MASK;
                     cap_valid_in = 1'b1;
                  end else begin
                     play_intf_in  = pending_intf_ff;
                     play_ep_in    = ep_addr_ff[3:0] & ADDR_NUM_MASK;
                     play_valid_in = 1'b1;
                  end
               end
               ep_pending_in = 1'b0;
            end
         end else begin
            // Other descriptor bodies carry nothing to record
         end

         // Advance within the descriptor or wrap to the next one
         if (!short_stop) begin
            if (pos_next_wide >= {1'b0, length_in}) begin
               pos_in = '0;
               if (type_in != TYPE_INTERFACE) begin
                  ep_pending_in = 1'b0;
               end
            end else begin
               pos_in = pos_next_wide[7:0];
            end
         end
      end
   end

   // Summary from the updated state
   always_comb begin
      result.audio_seen    = found_in;
      result.in_interface  = cap_valid_in ? cap_intf_in : 8'd0;
      result.in_endpoint   = cap_valid_in ? cap_ep_in : 4'd0;
      result.in_doorbell   = cap_valid_in ? {cap_ep_in, 1'b1} : 5'd0;
      result.out_interface = play_valid_in ? play_intf_in : 8'd0;
      result.out_endpoint  = play_valid_in ? play_ep_in : 4'd0;
      result.out_doorbell  = play_valid_in ? {play_ep_in, 1'b0} : 5'd0;
   end

   // Commit the step; clear everything after the last byte of a buffer
   always_ff @(posedge clock) begin
      if (reset || (step_en && step_last)) begin
         pos_ff          <= '0;
         length_ff       <= '0;
         type_ff         <= '0;
         intf_num_ff     <= '0;
         intf_sub_ff     <= '0;
         class_match_ff  <= 1'b0;
         ep_pending_ff   <= 1'b0;
         pending_intf_ff <= '0;
         ep_addr_ff      <= '0;
         stopped_ff      <= 1'b0;
         found_ff        <= 1'b0;
         cap_intf_ff     <= '0;
         cap_ep_ff       <= '0;
         cap_valid_ff    <= 1'b0;
         play_intf_ff    <= '0;
         play_ep_ff      <= '0;
         play_valid_ff   <= 1'b0;
      end else if (step_en) begin
         pos_ff          <= pos_in;
         length_ff       <= length_in;
         type_ff         <= type_in;
         intf_num_ff     <= intf_num_in;
         intf_sub_ff     <= intf_sub_in;
         class_match_ff  <= class_match_in;
         ep_pending_ff   <= ep_pending_in;
         pending_intf_ff <= pending_intf_in;
         ep_addr_ff      <= ep_addr_in;
         stopped_ff      <= stopped_in;
         found_ff        <= found_in;
         cap_intf_ff     <= cap_intf_in;
         cap_ep_ff       <= cap_ep_in;
         cap_valid_ff    <= cap_valid_in;
         play_intf_ff    <= play_intf_in;
         play_ep_ff      <= play_ep_in;
         play_valid_ff   <= play_valid_in;
      end
   end

endmodule

[design/usb_audio_descriptor_scanner.sv]
// ----------------------------------------------------------------------------
// usb_audio_descriptor_scanner
// Walks a USB configuration descriptor buffer byte by byte and reports the
// UAC2 audio streaming interfaces and isochronous endpoints it finds.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one descriptor byte per item, req_last_byte marks the buffer end.
//   rsp_*  : one summary item per buffer, produced for the last byte only.
//   csr_*  : APB-style register port; registers at byte addresses 0, 4, 8, 12
//            (audio class, UAC2 protocol, streaming subclass, isochronous type).
//            Write only while no buffer is in flight.
// Timing:
//   An accepted byte lands in the input register and is folded into the scan
//   state as it leaves it; a last byte's summary goes into the result
//   register at that edge and shows on rsp_*. One byte per cycle is sustained
//   unless a last byte stalls; the scan update is a single level of compares and selects.
// Reset clears the scan state and loads the register defaults. When rsp_ready
//   is low, a waiting summary holds; bytes that are not last keep flowing, and
//   the next last byte waits in the input register until the summary leaves.
// ----------------------------------------------------------------------------
module usb_audio_descriptor_scanner (
   input  logic                            clock,
   input  logic                            reset,
   // input channel
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [7:0]                      req_desc_byte,
   input  logic                            req_last_byte,
   // result channel
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_audio_seen,
   output logic [7:0]                      rsp_in_interface,
   output logic [3:0]                      rsp_in_endpoint,
   output logic [4:0]                      rsp_in_doorbell,
   output logic [7:0]                      rsp_out_interface,
   output logic [3:0]                      rsp_out_endpoint,
   output logic [4:0]                      rsp_out_doorbell,
   // register port
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [uads_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [uads_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [uads_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);
   import uads_pkg::*;

   cfg_type       cfg_ff;
   csr_index_type csr_index;
   logic          csr_write;

   logic          s1_valid_ff;
   logic [7:0]    s1_byte_ff;
   logic          s1_last_ff;
   logic          s1_advance;
   logic          rsp_free;
   logic          req_take;

   result_type    scan_result;
   result_type    rsp_data_ff;
   logic          rsp_valid_ff;

   // Register port decode
   assign csr_pready = 1'b1;
   assign csr_index  = csr_index_type'(csr_paddr[3:2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.audio_class        <= 8'd1;
         cfg_ff.uac2_protocol      <= 8'd32;
         cfg_ff.streaming_subclass <= 8'd2;
         cfg_ff.isoch_type         <= 2'd1;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_AUDIO_CLASS:   cfg_ff.audio_class        <= csr_pwdata[7:0];
            CSR_UAC2_PROTOCOL: cfg_ff.uac2_protocol      <= csr_pwdata[7:0];
            CSR_STREAM_SUBCLS: cfg_ff.streaming_subclass <= csr_pwdata[7:0];
            CSR_ISOCH_TYPE:    cfg_ff.isoch_type         <= csr_pwdata[1:0];
            default: ;
         endcase
      end
   end

   // Read back the selected register
   always_comb begin
      unique case (csr_index)
         CSR_AUDIO_CLASS:   csr_prdata = {24'd0, cfg_ff.audio_class};
         CSR_UAC2_PROTOCOL: csr_prdata = {24'd0, cfg_ff.uac2_protocol};
         CSR_STREAM_SUBCLS: csr_prdata = {24'd0, cfg_ff.streaming_subclass};
         CSR_ISOCH_TYPE:    csr_prdata = {30'd0, cfg_ff.isoch_type};
         default:           csr_prdata = '0;
      endcase
   end

   // Flow control: a last byte moves on only into a free result register
   assign rsp_free   = !rsp_valid_ff || rsp_ready;
   assign s1_advance = s1_valid_ff && (!s1_last_ff || rsp_free);
   assign req_ready  = !s1_valid_ff || s1_advance;
   assign req_take   = req_valid && req_ready;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_take) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_byte_ff <= req_desc_byte;
         s1_last_ff <= req_last_byte;
      end
   end

   uads_scan u_scan (
      .clock     (clock),
      .reset     (reset),
      .step_en   (s1_advance),
      .step_byte (s1_byte_ff),
      .step_last (s1_last_ff),
      .cfg       (cfg_ff),
      .result    (scan_result)
   );

   // Result register: load on a last byte, drop once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_advance && s1_last_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance && s1_last_ff) begin
         rsp_data_ff <= scan_result;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_audio_seen    = rsp_data_ff.audio_seen;
   assign rsp_in_interface  = rsp_data_ff.in_interface;
   assign rsp_in_endpoint   = rsp_data_ff.in_endpoint;
   assign rsp_in_doorbell   = rsp_data_ff.in_doorbell;
   assign rsp_out_interface = rsp_data_ff.out_interface;
   assign rsp_out_endpoint  = rsp_data_ff.out_endpoint;
   assign rsp_out_doorbell  = rsp_data_ff.out_doorbell;

   // Only a last byte facing a full result register blocks the input
   a_ready_block: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (s1_valid_ff && s1_last_ff && rsp_valid_ff && !rsp_ready))
      else $error("input blocked without a pending last byte");

   // A held byte stays in the input register
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_advance) |=> (s1_valid_ff && $stable(s1_byte_ff)
                                        && $stable(s1_last_ff)))
      else $error("input register lost a stalled byte");

   // Capture doorbell is zero or 2n+1 of the capture endpoint
   a_in_doorbell: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_in_doorbell == 5'd0 ||
                        (rsp_in_doorbell[0] && rsp_in_doorbell[4:1] == rsp_in_endpoint)))
      else $error("capture doorbell inconsistent");

   // Playback doorbell is 2n of the playback endpoint
   a_out_doorbell: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (!rsp_out_doorbell[0] && rsp_out_doorbell[4:1] == rsp_out_endpoint))
      else $error("playback doorbell inconsistent");

endmodule
